// File: rtl/core/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared constants for the double-ended queue: field widths, command and
// status codes, parameter defaults.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;

   localparam int CMD_W  = 4;
   localparam int WORD_W = 32;
   localparam int POS_W  = 4;
   localparam int CNT_W  = 5;
   localparam int ST_W   = 2;

   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 4'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 4'd1;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 4'd2;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 4'd3;
   localparam logic [CMD_W-1:0] CMD_READ_AT    = 4'd4;
   localparam logic [CMD_W-1:0] CMD_INSERT     = 4'd5;
   localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd6;
   localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 4'd7;
   localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 4'd8;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_INDEX = 2'd1;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

endpackage

// File: rtl/core/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of data words in a ring RAM, one request at a time.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. busy stays high
// until the cycle in which the response is strobed on rsp_strobe. The strobe
// lasts one cycle, and the receiver cannot stall: it must take the response
// then. The following requests strobe straight from the execute state: push,
// clear, unused codes, insert into an empty queue, and any failed request.
// Pop, peek and read-at pass through a read-wait state first because of the
// RAM's registered read. Insert-after moves each later word one place back
// through the RAM and the shared slot adder, with a read state and a write
// state per word. The longest insert is one after the front of a queue
// holding DEPTH - 1 words. The RAM is not cleared after reset; only written
// entries are ever read.
module double_ended_queue
   import deq_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [WORD_W-1:0] req_value,
   input  logic [POS_W-1:0]  req_position,
   output logic              busy,
   output logic              rsp_strobe,
   output logic [WORD_W-1:0] rsp_read_word,
   output logic [CNT_W-1:0]  rsp_count,
   output logic [ST_W-1:0]   rsp_status
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_RDWAIT = 3'd2;
   localparam logic [2:0] S_SHRD   = 3'd3;
   localparam logic [2:0] S_SHWR   = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [DATA_WIDTH-1:0] value_ff, value_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [AW-1:0]         front_ff, front_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [WORD_W-1:0]     rsp_word_ff, rsp_word_in;
   logic [CNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic [ST_W-1:0]       rsp_status_ff, rsp_status_in;

   logic [AW-1:0]         slot_off, slot;
   logic                  ram_we;
   logic [AW-1:0]         ram_waddr, ram_raddr;
   logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

   logic                  empty, full, pos_ok;

   deq_slot #(.DEPTH(DEPTH), .AW(AW)) u_slot (
      .base   (front_ff),
      .offset (slot_off),
      .slot   (slot)
   );

   deq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH), .AW(AW)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign empty  = (count_ff == '0);
   assign full   = (count_ff == CW'(DEPTH));
   assign pos_ok = (32'(pos_ff) < 32'(count_ff));

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      value_in      = value_ff;
      pos_in        = pos_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;
      rsp_status_in = rsp_status_ff;
      slot_off      = '0;
      ram_we        = 1'b0;
      ram_wdata     = value_ff;
      ram_waddr     = slot;
      ram_raddr     = slot;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in   = req_command;
               value_in = DATA_WIDTH'(req_value);
               pos_in   = req_position;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in      = S_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_word_in   = '0;
            rsp_status_in = ST_OK;
            unique case (cmd_ff)
               CMD_PUSH_BACK: begin
                  if (full) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     slot_off = AW'(count_ff);
                     ram_we   = 1'b1;
                     count_in = count_ff + CW'(1);
                  end
               end
               CMD_PUSH_FRONT: begin
                  if (full) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     slot_off = AW'(DEPTH - 1);
                     ram_we   = 1'b1;
                     front_in = slot;
                     count_in = count_ff + CW'(1);
                  end
               end
               CMD_POP_BACK, CMD_PEEK_BACK: begin
                  if (empty) begin
                     rsp_status_in = ST_EMPTY;
                  end else begin
                     slot_off      = AW'(count_ff - CW'(1));
                     rsp_strobe_in = 1'b0;
                     state_in      = S_RDWAIT;
                     if (cmd_ff == CMD_POP_BACK) begin
                        count_in = count_ff - CW'(1);
                     end
                  end
               end
               CMD_POP_FRONT, CMD_PEEK_FRONT: begin
                  if (empty) begin
                     rsp_status_in = ST_EMPTY;
                  end else begin
                     ram_raddr     = front_ff;
                     rsp_strobe_in = 1'b0;
                     state_in      = S_RDWAIT;
                     if (cmd_ff == CMD_POP_FRONT) begin
                        slot_off = AW'(1);
                        front_in = slot;
                        count_in = count_ff - CW'(1);
                     end
                  end
               end
               CMD_READ_AT: begin
                  if (!pos_ok) begin
                     rsp_status_in = ST_INDEX;
                  end else begin
                     slot_off      = AW'(pos_ff);
                     rsp_strobe_in = 1'b0;
                     state_in      = S_RDWAIT;
                  end
               end
               CMD_INSERT: begin
                  if (empty) begin
                     if (pos_ff == '0) begin
                        ram_we   = 1'b1;
                        count_in = CW'(1);
                     end else begin
                        rsp_status_in = ST_INDEX;
                     end
                  end else if (!pos_ok) begin
                     rsp_status_in = ST_INDEX;
                  end else if (full) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     idx_in        = count_ff;
                     rsp_strobe_in = 1'b0;
                     state_in      = S_SHRD;
                  end
               end
               CMD_CLEAR: begin
                  count_in = '0;
                  front_in = '0;
               end
               default: begin
               end
            endcase
         end
         S_RDWAIT: begin
            rsp_strobe_in = 1'b1;
            rsp_word_in   = WORD_W'(ram_rdata);
            rsp_status_in = ST_OK;
            state_in      = S_IDLE;
         end
         S_SHRD: begin
            if (32'(idx_ff) > 32'(pos_ff) + 32'd1) begin
               // fetch the word that moves into slot idx
               slot_off = AW'(idx_ff - CW'(1));
               state_in = S_SHWR;
            end else begin
               slot_off      = AW'(pos_ff) + AW'(1);
               ram_we        = 1'b1;
               count_in      = count_ff + CW'(1);
               rsp_strobe_in = 1'b1;
               rsp_word_in   = '0;
               rsp_status_in = ST_OK;
               state_in      = S_IDLE;
            end
         end
         S_SHWR: begin
            slot_off  = AW'(idx_ff);
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            idx_in    = idx_ff - CW'(1);
            state_in  = S_SHRD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_count_in = rsp_strobe_in ? CNT_W'(count_in) : rsp_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         front_ff      <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         front_ff      <= front_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      value_ff      <= value_in;
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_read_word = rsp_word_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

// File: rtl/core/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/deq_slot.sv
// ----------------------------------------------------------------------------
// deq_slot
// Ring slot adder: slot of element offset from the front, modulo DEPTH.
// ----------------------------------------------------------------------------
module deq_slot #(
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic [AW-1:0] base,
   input  logic [AW-1:0] offset,
   output logic [AW-1:0] slot
);

   localparam logic [AW:0] DEPTH_V = (AW+1)'(DEPTH);

   logic [AW:0] sum;

   always_comb begin
      sum = {1'b0, base} + {1'b0, offset};
      if (sum >= DEPTH_V) begin
         sum = sum - DEPTH_V;
      end
      slot = sum[AW-1:0];
   end

endmodule

// File: rtl/core/deq_checker.sv
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks for the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker
   import deq_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input logic [WORD_W-1:0] rsp_read_word,
   input logic [ST_W-1:0]   rsp_status
);

   // an accepted request holds the block until its response
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_strobe))
      else $error("request accepted but block not busy");

   a_strobe_single : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for two cycles");

   a_strobe_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response strobed while still busy");

   a_fail_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != ST_OK)) |-> (rsp_read_word == '0))
      else $error("failed request returned a non-zero word");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_strobe    (rsp_strobe),
   .rsp_read_word (rsp_read_word),
   .rsp_status    (rsp_status)
);

// File: sim/double_ended_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Self-checking bench for the ring-buffer deque. A directed opening covers
// the empty, bad-index and wrap-around corners. Random fill, drain and mixed
// runs follow: they reach a full queue, long inserts and unused codes. Each
// response is checked against a shadow deque kept inside the bench.
// ----------------------------------------------------------------------------
module double_ended_queue_tb
   import deq_pkg::*;
();

   localparam int DEPTH       = DEPTH_DEF;
   localparam int N_RANDOM    = 950;
   localparam int QUIET_TAIL  = 100;
   localparam int DRAIN_WAIT  = 3 + 2 * DEPTH + 8;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [WORD_W-1:0] value;
      logic [POS_W-1:0]  position;
   } deq_req_type;

   typedef struct packed {
      logic [WORD_W-1:0] read_word;
      logic [CNT_W-1:0]  count;
      logic [ST_W-1:0]   status;
   } deq_rsp_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic [CMD_W-1:0]  req_command = '0;
   logic [WORD_W-1:0] req_value = '0;
   logic [POS_W-1:0]  req_position = '0;
   logic              busy;
   logic              rsp_strobe;
   logic [WORD_W-1:0] rsp_read_word;
   logic [CNT_W-1:0]  rsp_count;
   logic [ST_W-1:0]   rsp_status;

   double_ended_queue dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_command   (req_command),
      .req_value     (req_value),
      .req_position  (req_position),
      .busy          (busy),
      .rsp_strobe    (rsp_strobe),
      .rsp_read_word (rsp_read_word),
      .rsp_count     (rsp_count),
      .rsp_status    (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow deque
   logic [WORD_W-1:0] shadow_ring [DEPTH];
   int                shadow_front = 0;
   int                shadow_count = 0;

   deq_req_type req_backlog_q [$];
   deq_rsp_type rsp_due_q [$];
   int          req_total = 0;
   int          req_sent = 0;
   int          rsp_seen = 0;
   int          fail_count = 0;
   int          status_tally [4] = '{0, 0, 0, 0};
   int          idle_left = 0;
   int          cycle_count = 0;

   function automatic int slot_at(int idx);
      return (shadow_front + idx) % DEPTH;
   endfunction

   function automatic deq_rsp_type deque_next(deq_req_type r);
      deq_rsp_type o;
      int          pos;
      pos = int'(r.position);
      o.read_word = '0;
      o.status    = ST_OK;
      case (r.command)
         CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
            if (shadow_count >= DEPTH) begin
               o.status = ST_FULL;
            end else if (r.command == CMD_PUSH_BACK) begin
               shadow_ring[slot_at(shadow_count)] = r.value;
               shadow_count++;
            end else begin
               shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
               shadow_ring[shadow_front] = r.value;
               shadow_count++;
            end
         end
         CMD_POP_BACK: begin
            if (shadow_count == 0) begin
               o.status = ST_EMPTY;
            end else begin
               shadow_count--;
               o.read_word = shadow_ring[slot_at(shadow_count)];
            end
         end
         CMD_POP_FRONT: begin
            if (shadow_count == 0) begin
               o.status = ST_EMPTY;
            end else begin
               o.read_word = shadow_ring[shadow_front];
               shadow_front = slot_at(1);
               shadow_count--;
            end
         end
         CMD_READ_AT: begin
            if (pos >= shadow_count) o.status = ST_INDEX;
            else o.read_word = shadow_ring[slot_at(pos)];
         end
         CMD_INSERT: begin
            if (shadow_count == 0) begin
               if (pos == 0) begin
                  shadow_ring[slot_at(0)] = r.value;
                  shadow_count = 1;
               end else begin
                  o.status = ST_INDEX;
               end
            end else if (pos >= shadow_count) begin
               o.status = ST_INDEX;
            end else if (shadow_count >= DEPTH) begin
               o.status = ST_FULL;
            end else begin
               for (int i = shadow_count; i > pos + 1; i--)
                  shadow_ring[slot_at(i)] = shadow_ring[slot_at(i - 1)];
               shadow_ring[slot_at(pos + 1)] = r.value;
               shadow_count++;
            end
         end
         CMD_CLEAR: begin
            shadow_count = 0;
            shadow_front = 0;
         end
         CMD_PEEK_FRONT: begin
            if (shadow_count == 0) o.status = ST_EMPTY;
            else o.read_word = shadow_ring[shadow_front];
         end
         CMD_PEEK_BACK: begin
            if (shadow_count == 0) o.status = ST_EMPTY;
            else o.read_word = shadow_ring[slot_at(shadow_count - 1)];
         end
         default: ;
      endcase
      o.count = CNT_W'(shadow_count);
      return o;
   endfunction

   // driver: start held high across busy, so the next request waits on the bus
   always @(posedge clock) begin
      deq_req_type nxt;
      logic        fire;
      if (reset) begin
         start <= 1'b0;
      end else begin
         fire = start && !busy;
         if (fire) begin
            rsp_due_q.insert(rsp_due_q.size(),
                             deque_next('{req_command, req_value, req_position}));
            req_sent++;
            if (req_sent < req_total - QUIET_TAIL && $urandom_range(0, 3) == 0)
               idle_left = $urandom_range(1, 17);
         end
         if (fire || !start) begin
            if (idle_left > 0) begin
               idle_left--;
               start <= 1'b0;
            end else if (req_backlog_q.size() > 0) begin
               nxt = req_backlog_q[0];
               req_backlog_q.delete(0);
               start        <= 1'b1;
               req_command  <= nxt.command;
               req_value    <= nxt.value;
               req_position <= nxt.position;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      deq_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (rsp_due_q.size() == 0) begin
            $error("response with none outstanding: read_word %h count %0d status %0d",
                   rsp_read_word, rsp_count, rsp_status);
            fail_count++;
         end else begin
            want = rsp_due_q[0];
            rsp_due_q.delete(0);
            rsp_seen++;
            status_tally[want.status]++;
            if (rsp_read_word !== want.read_word) begin
               $error("read_word: expected %h, got %h", want.read_word, rsp_read_word);
               fail_count++;
            end
            if (rsp_count !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, rsp_count);
               fail_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, rsp_due_q.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic queue_req(logic [CMD_W-1:0] c, logic [WORD_W-1:0] v,
                            logic [POS_W-1:0] p);
      deq_req_type item;
      item = '{c, v, p};
      req_backlog_q.insert(req_backlog_q.size(), item);
   endtask

   function automatic logic [WORD_W-1:0] any_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return WORD_W'($urandom);
      endcase
   endfunction

   function automatic logic [POS_W-1:0] any_pos();
      if ($urandom_range(0, 3) == 0) return POS_W'($urandom_range(0, 15));
      return POS_W'($urandom_range(0, 4));
   endfunction

   // any code, unused ones included
   function automatic logic [CMD_W-1:0] CMD_WIDTH_ANY();
      return CMD_W'($urandom_range(0, 15));
   endfunction

   initial begin
      int run_len;
      int pick;
      logic [CMD_W-1:0] c;

      // directed opening
      queue_req(CMD_POP_BACK,   '0, '0);
      queue_req(CMD_POP_FRONT,  '0, '0);
      queue_req(CMD_PEEK_FRONT, '0, '0);
      queue_req(CMD_PEEK_BACK,  '0, '0);
      queue_req(CMD_READ_AT,    '0, '0);
      queue_req(CMD_INSERT,     32'h1234_5678, 4'd5);
      queue_req(CMD_INSERT,     32'hFFFF_FFFF, 4'd0);
      queue_req(CMD_PUSH_BACK,  32'h0000_0000, 4'd15);
      queue_req(CMD_PUSH_FRONT, 32'hA5A5_5A5A, '0);
      queue_req(CMD_READ_AT,    '0, 4'd2);
      queue_req(CMD_READ_AT,    '0, 4'd3);
      queue_req(CMD_INSERT,     32'h0F0F_F0F0, 4'd0);
      queue_req(CMD_INSERT,     32'h5555_AAAA, 4'd15);
      queue_req(CMD_PEEK_FRONT, '0, '0);
      queue_req(CMD_PEEK_BACK,  '0, '0);
      queue_req(4'd9,           32'hDEAD_BEEF, 4'd1);
      queue_req(4'd15,          32'hFFFF_FFFF, 4'd15);
      queue_req(CMD_POP_BACK,   '0, '0);
      queue_req(CMD_POP_FRONT,  '0, '0);
      queue_req(CMD_CLEAR,      '1, '1);
      queue_req(CMD_POP_FRONT,  '0, '0);
      queue_req(CMD_PUSH_FRONT, 32'h8000_0000, '0);
      queue_req(CMD_PUSH_FRONT, 32'h0000_0001, '0);
      queue_req(CMD_READ_AT,    '0, 4'd1);
      queue_req(CMD_INSERT,     32'h7FFF_FFFF, 4'd1);

      // random runs: fill towards full, drain towards empty, or mixed noise
      while (req_backlog_q.size() < 25 + N_RANDOM) begin
         pick    = $urandom_range(0, 2);
         run_len = $urandom_range(12, 26);
         repeat (run_len) begin
            case (pick)
               0: case ($urandom_range(0, 9))
                     0, 1, 2, 3: c = CMD_PUSH_BACK;
                     4, 5, 6:    c = CMD_PUSH_FRONT;
                     default:    c = CMD_INSERT;
                  endcase
               1: case ($urandom_range(0, 9))
                     0, 1, 2: c = CMD_POP_BACK;
                     3, 4, 5: c = CMD_POP_FRONT;
                     6:       c = CMD_PEEK_FRONT;
                     7:       c = CMD_PEEK_BACK;
                     default: c = CMD_READ_AT;
                  endcase
               default: begin
                  if ($urandom_range(0, 4) == 0) c = CMD_WIDTH_ANY();
                  else c = CMD_W'($urandom_range(0, 8));
               end
            endcase
            queue_req(c, any_word(), any_pos());
         end
      end
      req_total = req_backlog_q.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (req_sent < req_total) @(posedge clock);
      while (rsp_due_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("%0d requests sent, %0d responses checked in %0d cycles",
               req_sent, rsp_seen, cycle_count);
      $display("status seen: ok %0d, bad index %0d, empty %0d, full %0d",
               status_tally[ST_OK], status_tally[ST_INDEX],
               status_tally[ST_EMPTY], status_tally[ST_FULL]);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
